// File: rtl/binary_to_ascii_digits_defines.svh
// Assertion macros for the binary to ASCII digit converter.
`ifndef BINARY_TO_ASCII_DIGITS_DEFINES_SVH
`define BINARY_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BTA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bta assertion failed: same-cycle implication");

`define BTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bta assertion failed: next-cycle implication");

`else

`define BTA_ASSERT_IMPL(label, ante, cons)

`define BTA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/bta_pkg.sv
// Shared constants, command/status types and digit helpers for the converter.
package bta_pkg;

    localparam int MODE_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS_MAX  = 10;
    localparam int DIG_IDX_W   = 4;
    localparam int SHIFT_CNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_DEC8  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEC16 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEC32 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX8  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEX16 = 3'd4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 8'h61;

    typedef logic [DIGITS_MAX-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode_ok;
        logic mode_dec;
        logic shift_done;
        logic dig_done;
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
        if (nib < 4'd10)
            return ASCII_ZERO + wide;
        else
            return ASCII_A + wide - 8'd10;
    endfunction

    function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
        if (d >= 4'd5)
            return d + 4'd3;
        else
            return d;
    endfunction

endpackage

// File: rtl/bta_if.sv
// Channel interfaces for the converter: input word and output word.
interface bta_in_if;
    import bta_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bta_out_if;
    import bta_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/bta_datapath.sv
// Datapath: value shifter, BCD double-dabble register, digit counters, output word.
module bta_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bta_pkg::MODE_W-1:0]  mode,
    input  logic [bta_pkg::VALUE_W-1:0] value,
    input  bta_pkg::ctrl_cmd_t          cmd,
    output bta_pkg::dp_status_t         status,
    output logic [bta_pkg::CHAR_W-1:0]  character,
    output logic                        last
);
    import bta_pkg::*;

    logic [VALUE_W-1:0]     val_reg;
    logic [VALUE_W-1:0]     val_next;
    digits_t                bcd_reg;
    digits_t                bcd_next;
    digits_t                bcd_adj;
    logic [DIGITS_MAX*DIGIT_W-1:0] adj_bits;
    logic [SHIFT_CNT_W-1:0] cnt_reg;
    logic [SHIFT_CNT_W-1:0] cnt_next;
    logic [DIG_IDX_W-1:0]   dig_reg;
    logic [DIG_IDX_W-1:0]   dig_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;

    always_comb
    begin
        status.mode_ok    = 1'b0;
        status.mode_dec   = 1'b0;
        case (mode) inside
            MODE_DEC8, MODE_DEC16, MODE_DEC32:
            begin
                status.mode_ok  = 1'b1;
                status.mode_dec = 1'b1;
            end
            MODE_HEX8, MODE_HEX16:
            begin
                status.mode_ok  = 1'b1;
            end
            default:
            begin
                status.mode_ok  = 1'b0;
            end
        endcase
        status.shift_done = (cnt_reg == '0);
        status.dig_done   = (dig_reg == '0);
    end

    always_comb
    begin
        for (int g = 0; g < DIGITS_MAX; g++)
            bcd_adj[g] = dabble_adjust(bcd_reg[g]);
    end

    assign adj_bits = bcd_adj;

    always_comb
    begin
        val_next  = val_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        dig_next  = dig_reg;
        char_next = char_reg;
        last_next = last_reg;

        if (cmd.load)
        begin
            bcd_next = '0;
            cnt_next = '0;
            case (mode)
                MODE_DEC8:
                begin
                    val_next = {value[7:0], 24'b0};
                    cnt_next = 5'd7;
                    dig_next = 4'd2;
                end
                MODE_DEC16:
                begin
                    val_next = {value[15:0], 16'b0};
                    cnt_next = 5'd15;
                    dig_next = 4'd4;
                end
                MODE_DEC32:
                begin
                    val_next = value;
                    cnt_next = 5'd31;
                    dig_next = 4'd9;
                end
                MODE_HEX8:
                begin
                    bcd_next = digits_t'({32'b0, value[7:0]});
                    dig_next = 4'd1;
                end
                MODE_HEX16:
                begin
                    bcd_next = digits_t'({24'b0, value[15:0]});
                    dig_next = 4'd3;
                end
                default:
                begin
                    dig_next = dig_reg;
                end
            endcase
        end
        else if (cmd.shift)
        begin
            bcd_next = digits_t'({adj_bits[DIGITS_MAX*DIGIT_W-2:0], val_reg[VALUE_W-1]});
            val_next = {val_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cmd.emit)
        begin
            char_next = to_ascii(bcd_reg[dig_reg]);
            last_next = (dig_reg == '0);
            dig_next  = dig_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            dig_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            dig_reg <= dig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign character = char_reg;
    assign last      = last_reg;

endmodule

// File: rtl/bta_controller.sv
// Controller: sequences load, double-dabble shifts and digit emission.
module bta_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bta_pkg::dp_status_t status,
    output bta_pkg::ctrl_cmd_t  cmd
);
    import bta_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && status.mode_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.mode_dec ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.shift_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.dig_done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/binary_to_ascii_digits.sv
// Top level of the binary to ASCII digit converter.
//
//   channel   dir  payload                  handshake
//   in_word   in   mode[2:0], value[31:0]   valid/ready
//   out_word  out  character[7:0], last     valid/ready
//
// Decimal words take a load, then 8, 16 or 32 double-dabble shifts, then
// one digit per cycle (3, 5 or 10) while the output is not stalled; hex words
// skip the shifts. All modes share the single BCD shift register.
// Reset clears the controller and the datapath counters; value, BCD and char regs are not reset.
// A stalled output holds the digit sequencer; a new word is taken once the last
// digit sits in the output register. Unused modes are taken and give no words.
`include "binary_to_ascii_digits_defines.svh"

module binary_to_ascii_digits (
    input  logic       clk,
    input  logic       rst_n,
    bta_in_if.sink     in_word,
    bta_out_if.source  out_word
);
    import bta_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bta_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .out_valid (out_word.valid),
        .out_ready (out_word.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bta_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (in_word.mode),
        .value     (in_word.value),
        .cmd       (cmd),
        .status    (status),
        .character (out_word.character),
        .last      (out_word.last)
    );

    `BTA_ASSERT_IMPL(a_load_on_accept, cmd.load, in_word.valid && in_word.ready)
    `BTA_ASSERT_NEXT(a_emit_fills_output, cmd.emit, out_word.valid)
    `BTA_ASSERT_NEXT(a_final_digit_frees_input, cmd.emit && status.dig_done, in_word.ready)

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the binary to ASCII digit converter.
`timescale 1ns / 1ps

module testbench;
    import bta_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam int RANDOM_WORDS = 80;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        bit                 drain;
    } number_word_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_word_t;

    logic clk;
    logic rst_n;

    bta_in_if  in_word();
    bta_out_if out_word();

    binary_to_ascii_digits uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .out_word (out_word)
    );

    number_word_t numbers_pending[$];
    digit_word_t  digits_owed[$];
    int           owed_count;
    int           numbers_taken;
    int           mismatches;
    int           send_gap;
    int           recv_stall;
    bit           quiet;
    bit           hold_off;

    function automatic void predict_digits(input logic [MODE_W-1:0] mode,
                                           input logic [VALUE_W-1:0] value);
        int                 count;
        bit                 decimal;
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digs[DIGITS_MAX];
        logic [DIGIT_W-1:0] nib;
        digit_word_t        d;
        count = 0;
        decimal = 1'b0;
        rest = value;
        case (mode)
            MODE_DEC8:
            begin
                count = 3;
                decimal = 1'b1;
                rest = value & 32'hFF;
            end
            MODE_DEC16:
            begin
                count = 5;
                decimal = 1'b1;
                rest = value & 32'hFFFF;
            end
            MODE_DEC32:
            begin
                count = 10;
                decimal = 1'b1;
            end
            MODE_HEX8:
            begin
                count = 2;
                rest = value & 32'hFF;
            end
            MODE_HEX16:
            begin
                count = 4;
                rest = value & 32'hFFFF;
            end
            default:
            begin
                count = 0;
            end
        endcase
        if (decimal)
        begin
            for (int i = 0; i < count; i++)
            begin
                digs[i] = DIGIT_W'(rest % 10);
                rest = rest / 10;
            end
        end
        else
        begin
            for (int i = 0; i < count; i++)
                digs[i] = DIGIT_W'(rest >> (4 * i));
        end
        for (int i = 0; i < count; i++)
        begin
            nib = digs[count - 1 - i];
            if (nib < 4'd10)
                d.code = ASCII_ZERO + CHAR_W'(nib);
            else
                d.code = ASCII_A + CHAR_W'(nib) - 8'd10;
            d.last = (i == count - 1);
            digits_owed.push_back(d);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2: return 32'hFFFF_FFFF;
            3: return 32'h1 << $urandom_range(0, 31);
            4: return $urandom & 32'hFFFF;
            default: return $urandom_range(0, 99999) | ($urandom & 32'hFFFF_0000);
        endcase
    endfunction

    task automatic queue_number(input logic [MODE_W-1:0] mode,
                                input logic [VALUE_W-1:0] value,
                                input bit drain);
        number_word_t w;
        w.mode = mode;
        w.value = value;
        w.drain = drain;
        numbers_pending.push_back(w);
    endtask

    task automatic log_mismatch(input string what, input digit_word_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, want.code, want.last, out_word.character, out_word.last);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_word.valid = 1'b0;
        in_word.mode = '0;
        in_word.value = '0;
        out_word.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        #1;
        forever #1 clk = ~clk;
    end

    // send side
    always @(posedge clk or negedge rst_n)
    begin
        number_word_t w;
        if (!rst_n)
        begin
            in_word.valid <= 1'b0;
            in_word.mode <= '0;
            in_word.value <= '0;
            send_gap <= 0;
            quiet <= 1'b0;
        end
        else
        begin
            quiet <= (numbers_pending.size() <= 20);
            if (!in_word.valid || in_word.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_word.valid <= 1'b0;
                end
                else if (numbers_pending.size() != 0 &&
                         !(numbers_pending[0].drain && (in_word.valid || owed_count != 0)))
                begin
                    w = numbers_pending.pop_front();
                    in_word.mode <= w.mode;
                    in_word.value <= w.value;
                    in_word.valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 19);
                end
                else
                begin
                    in_word.valid <= 1'b0;
                end
            end
        end
    end

    // receive side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_word.ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (hold_off)
        begin
            out_word.ready <= 1'b0;
        end
        else if (recv_stall != 0)
        begin
            recv_stall <= recv_stall - 1;
            out_word.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            recv_stall <= $urandom_range(0, 18);
            out_word.ready <= 1'b0;
        end
        else
        begin
            out_word.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted numbers, check accepted digits
    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n)
        begin
            if (out_word.valid && out_word.ready)
            begin
                if (digits_owed.size() == 0)
                begin
                    want.code = 'x;
                    want.last = 'x;
                    log_mismatch("unexpected word", want);
                end
                else
                begin
                    want = digits_owed.pop_front();
                    if (out_word.character !== want.code || out_word.last !== want.last)
                        log_mismatch("wrong field", want);
                end
            end
            if (in_word.valid && in_word.ready)
            begin
                predict_digits(in_word.mode, in_word.value);
                numbers_taken <= numbers_taken + 1;
            end
            owed_count <= digits_owed.size();
        end
    end

    // long receiver hold-off so the block backs up
    initial
    begin
        hold_off = 1'b0;
        wait (numbers_taken >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int counted;
        logic [MODE_W-1:0] m;
        numbers_taken = 0;
        mismatches = 0;
        owed_count = 0;

        queue_number(MODE_DEC8, 32'd0, 1'b0);
        queue_number(MODE_DEC8, 32'd255, 1'b0);
        queue_number(MODE_DEC8, 32'hFFFF_FF64, 1'b0);
        queue_number(MODE_DEC16, 32'd0, 1'b0);
        queue_number(MODE_DEC16, 32'd65535, 1'b0);
        queue_number(MODE_DEC16, 32'hABCD_2710, 1'b0);
        queue_number(MODE_DEC32, 32'd0, 1'b0);
        queue_number(MODE_DEC32, 32'hFFFF_FFFF, 1'b0);
        queue_number(MODE_DEC32, 32'd1000000000, 1'b0);
        queue_number(MODE_DEC32, 32'd999999999, 1'b0);
        queue_number(MODE_HEX8, 32'd0, 1'b0);
        queue_number(MODE_HEX8, 32'hFF, 1'b0);
        queue_number(MODE_HEX8, 32'h1234_56A9, 1'b0);
        queue_number(MODE_HEX16, 32'd0, 1'b0);
        queue_number(MODE_HEX16, 32'hFFFF, 1'b0);
        queue_number(MODE_HEX16, 32'h0000_89AB, 1'b0);
        queue_number(MODE_HEX16, 32'h0123_CDEF, 1'b0);
        queue_number(MODE_SPARE_FIRST, 32'hFFFF_FFFF, 1'b0);
        queue_number(MODE_HEX8, 32'h5A, 1'b0);
        queue_number(MODE_SPARE_FIRST + 3'd1, 32'h0, 1'b0);
        queue_number(MODE_SPARE_LAST, 32'h8000_0001, 1'b0);
        queue_number(MODE_DEC8, 32'd100, 1'b0);

        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            end
            else
            begin
                m = MODE_W'($urandom_range(MODE_DEC8, MODE_HEX16));
                counted++;
            end
            queue_number(m, random_value(), counted == 70);
        end

        do
            @(posedge clk);
        while (numbers_pending.size() != 0 || in_word.valid);
        while (digits_owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
